@@ hw/rtl/srfbs_pkg.sv @@
// ----------------------------------------------------------------------------
// srfbs_pkg
// Shared constants and types for the styled rectangle fill byte stream.
// ----------------------------------------------------------------------------
package srfbs_pkg;

  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;

  // Input command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Panel command bytes
  localparam logic [7:0] CMD_COLSET = 8'h2A;
  localparam logic [7:0] CMD_ROWSET = 8'h2B;
  localparam logic [7:0] CMD_MEMWR  = 8'h2C;

  typedef enum logic [1:0] {
    STYLE_SOLID  = 2'd0,
    STYLE_DASHED = 2'd1,
    STYLE_DOTTED = 2'd2
  } style_t;

  // Position in the command stream: eleven header bytes, then pixels
  typedef enum logic [3:0] {
    HDR_COLSET  = 4'd0,
    HDR_X0_HI   = 4'd1,
    HDR_X0_LO   = 4'd2,
    HDR_X1_HI   = 4'd3,
    HDR_X1_LO   = 4'd4,
    HDR_ROWSET  = 4'd5,
    HDR_Y0_HI   = 4'd6,
    HDR_Y0_LO   = 4'd7,
    HDR_Y1_HI   = 4'd8,
    HDR_Y1_LO   = 4'd9,
    HDR_MEMWR   = 4'd10,
    HDR_PIXELS  = 4'd11
  } hdr_t;

endpackage

@@ hw/rtl/styled_rect_fill_byte_stream_core.sv @@
// ----------------------------------------------------------------------------
// styled_rect_fill_byte_stream_core
// Turns a latched rectangle fill request into the panel's byte stream.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | cmd, rect_x/y/w/h, fore/back_colour, style
//  out     | out_valid/out_ready| out_byte, is_data, last_byte
//
//  Each accepted advance item writes its byte into the result register;
//  one item per cycle is sustained, paced only by the result register.
//  A new item is taken while the result register is empty or being drained.
//  Load items and advances while idle give no result.
//  Synchronous active-high reset returns the block to idle with no result.
//
module styled_rect_fill_byte_stream_core #(
  parameter int SCREEN_WIDTH  = srfbs_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = srfbs_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] rect_x,
  input  logic [15:0] rect_y,
  input  logic [15:0] rect_w,
  input  logic [15:0] rect_h,
  input  logic [15:0] fore_colour,
  input  logic [15:0] back_colour,
  input  logic [1:0]  line_style,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        is_data,
  output logic        last_byte
);

  localparam logic [15:0] SW = 16'(SCREEN_WIDTH);
  localparam logic [15:0] SH = 16'(SCREEN_HEIGHT);

  logic              busy, busy_next;
  srfbs_pkg::hdr_t   header_index, header_index_next;
  logic [15:0]       win_x0, win_x0_next;
  logic [15:0]       win_y0, win_y0_next;
  logic [15:0]       clip_w, clip_w_next;
  logic [15:0]       clip_h, clip_h_next;
  logic [15:0]       col_count, col_count_next;
  logic [15:0]       row_count, row_count_next;
  logic              low_half, low_half_next;
  logic [15:0]       held_fore, held_fore_next;
  logic [15:0]       held_back, held_back_next;
  srfbs_pkg::style_t held_style, held_style_next;

  logic              take_load, take_adv, produce;
  logic [7:0]        byte_next;
  logic              data_next, last_next;
  logic [15:0]       x1, y1, colour;
  logic              draw, col_end, row_end;

  assign in_ready  = !out_valid || out_ready;
  assign take_load = in_valid && in_ready && (cmd == srfbs_pkg::CMD_LOAD);
  assign take_adv  = in_valid && in_ready && (cmd == srfbs_pkg::CMD_ADVANCE);

  // window end wraps to 16 bits for a zero size
  assign x1 = 16'(win_x0 + clip_w - 16'd1);
  assign y1 = 16'(win_y0 + clip_h - 16'd1);

  always_comb begin
    case (held_style)
      srfbs_pkg::STYLE_SOLID:  draw = 1'b1;
      srfbs_pkg::STYLE_DASHED: draw = !col_count[3];
      srfbs_pkg::STYLE_DOTTED: draw = !col_count[0];
      default:                 draw = 1'b0;
    endcase
  end

  assign colour  = draw ? held_fore : held_back;
  // counters never pass the clipped size, so equality marks the end
  assign col_end = (16'(col_count + 16'd1) == clip_w);
  assign row_end = (16'(row_count + 16'd1) == clip_h);

  always_comb begin
    busy_next         = busy;
    header_index_next = header_index;
    win_x0_next       = win_x0;
    win_y0_next       = win_y0;
    clip_w_next       = clip_w;
    clip_h_next       = clip_h;
    col_count_next    = col_count;
    row_count_next    = row_count;
    low_half_next     = low_half;
    held_fore_next    = held_fore;
    held_back_next    = held_back;
    held_style_next   = held_style;
    produce           = 1'b0;
    byte_next         = 8'h00;
    data_next         = 1'b1;
    last_next         = 1'b0;

    if (take_load && !busy && (rect_x < SW) && (rect_y < SH)) begin
      win_x0_next = rect_x;
      win_y0_next = rect_y;
      clip_w_next = ({1'b0, rect_x} + {1'b0, rect_w} > {1'b0, SW}) ?
                    16'(SW - rect_x) : rect_w;
      clip_h_next = ({1'b0, rect_y} + {1'b0, rect_h} > {1'b0, SH}) ?
                    16'(SH - rect_y) : rect_h;
      held_fore_next    = fore_colour;
      held_back_next    = back_colour;
      held_style_next   = srfbs_pkg::style_t'(line_style);
      col_count_next    = '0;
      row_count_next    = '0;
      low_half_next     = 1'b0;
      header_index_next = srfbs_pkg::HDR_COLSET;
      busy_next         = 1'b1;
    end else if (take_adv && busy) begin
      produce = 1'b1;
      if (header_index != srfbs_pkg::HDR_PIXELS) begin
        case (header_index)
          srfbs_pkg::HDR_COLSET: begin
            byte_next = srfbs_pkg::CMD_COLSET;
            data_next = 1'b0;
          end
          srfbs_pkg::HDR_X0_HI: byte_next = win_x0[15:8];
          srfbs_pkg::HDR_X0_LO: byte_next = win_x0[7:0];
          srfbs_pkg::HDR_X1_HI: byte_next = x1[15:8];
          srfbs_pkg::HDR_X1_LO: byte_next = x1[7:0];
          srfbs_pkg::HDR_ROWSET: begin
            byte_next = srfbs_pkg::CMD_ROWSET;
            data_next = 1'b0;
          end
          srfbs_pkg::HDR_Y0_HI: byte_next = win_y0[15:8];
          srfbs_pkg::HDR_Y0_LO: byte_next = win_y0[7:0];
          srfbs_pkg::HDR_Y1_HI: byte_next = y1[15:8];
          srfbs_pkg::HDR_Y1_LO: byte_next = y1[7:0];
          default: begin
            byte_next = srfbs_pkg::CMD_MEMWR;
            data_next = 1'b0;
          end
        endcase
        header_index_next = srfbs_pkg::hdr_t'(header_index + 4'd1);
        if ((header_index == srfbs_pkg::HDR_MEMWR) &&
            ((clip_w == 16'd0) || (clip_h == 16'd0))) begin
          last_next = 1'b1;
          busy_next = 1'b0;
        end
      end else if (!low_half) begin
        byte_next     = colour[15:8];
        low_half_next = 1'b1;
      end else begin
        byte_next      = colour[7:0];
        low_half_next  = 1'b0;
        col_count_next = 16'(col_count + 16'd1);
        if (col_end) begin
          col_count_next = '0;
          row_count_next = 16'(row_count + 16'd1);
          if (row_end) begin
            row_count_next = '0;
            last_next      = 1'b1;
            busy_next      = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      header_index <= srfbs_pkg::HDR_COLSET;
      col_count    <= '0;
      row_count    <= '0;
      low_half     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      busy         <= busy_next;
      header_index <= header_index_next;
      col_count    <= col_count_next;
      row_count    <= row_count_next;
      low_half     <= low_half_next;
      if (produce) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_x0     <= win_x0_next;
    win_y0     <= win_y0_next;
    clip_w     <= clip_w_next;
    clip_h     <= clip_h_next;
    held_fore  <= held_fore_next;
    held_back  <= held_back_next;
    held_style <= held_style_next;
    if (produce) begin
      out_byte  <= byte_next;
      is_data   <= data_next;
      last_byte <= last_next;
    end
  end

  // a result appears only from an accepted advance item
  a_result_from_advance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |->
      $past(in_valid && in_ready && (cmd == srfbs_pkg::CMD_ADVANCE)))
    else $error("result without an advance item");

  a_pixel_counters: assert property (@(posedge clk) disable iff (rst)
    (busy && (header_index == srfbs_pkg::HDR_PIXELS)) |->
      ((col_count < clip_w) && (row_count < clip_h)))
    else $error("pixel counters outside the clipped window");

  a_origin_on_screen: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((win_x0 < SW) && (win_y0 < SH)))
    else $error("window origin off screen while busy");

  a_last_command: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_byte && !is_data) |-> (out_byte == srfbs_pkg::CMD_MEMWR))
    else $error("final command byte is not memory write");

endmodule
